// ----- hdl/deq_pkg.sv -----
// Shared command codes, status codes and response metadata for the double-ended queue.
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_REAR  = 3'd5,
      CMD_CLEAR      = 3'd6,
      CMD_UNUSED     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic       valid;
      logic       use_data;
      status_type status;
   } rsp_meta_type;

endpackage

// ----- hdl/deq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = deq_pkg::DATA_WIDTH_DEFAULT,
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/deq_ctrl.sv -----
// Pointer, count and status control for the double-ended queue ring store.
module deq_ctrl #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [2:0]                 cmd,
   input  logic [DATA_WIDTH-1:0]      data,
   output logic                       wr_en,
   output logic [$clog2(DEPTH)-1:0]   wr_addr,
   output logic [DATA_WIDTH-1:0]      wr_data,
   output logic                       rd_en,
   output logic [$clog2(DEPTH)-1:0]   rd_addr,
   output deq_pkg::rsp_meta_type      meta,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] rear_ff, rear_in;
   logic [CW-1:0] count_ff, count_in;
   deq_pkg::rsp_meta_type meta_ff, meta_in;

   logic          at_empty;
   logic          is_full;
   logic [AW-1:0] front_next;
   logic [AW-1:0] front_prev;
   logic [AW-1:0] rear_next;
   logic [AW-1:0] rear_prev;

   always_comb begin
      at_empty   = (count_ff == '0);
      is_full    = (count_ff >= FULL_CNT);
      front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
      front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
      rear_next  = (rear_ff == LAST_IDX) ? '0 : rear_ff + 1'b1;
      rear_prev  = (rear_ff == '0) ? LAST_IDX : rear_ff - 1'b1;

      front_in         = front_ff;
      rear_in          = rear_ff;
      count_in         = count_ff;
      wr_en            = 1'b0;
      wr_addr          = rear_ff;
      wr_data          = data;
      rd_en            = 1'b0;
      rd_addr          = front_ff;
      meta_in.valid    = accept;
      meta_in.use_data = 1'b0;
      meta_in.status   = deq_pkg::ST_OK;

      if (accept) begin
         case (cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
               if (is_full) begin
                  meta_in.status = deq_pkg::ST_FULL;
               end else begin
                  front_in = front_prev;
                  wr_en    = 1'b1;
                  wr_addr  = front_prev;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_PUSH_REAR: begin
               if (is_full) begin
                  meta_in.status = deq_pkg::ST_FULL;
               end else begin
                  rear_in  = rear_next;
                  wr_en    = 1'b1;
                  wr_addr  = rear_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
               if (at_empty) begin
                  meta_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en            = 1'b1;
                  rd_addr          = front_ff;
                  meta_in.use_data = 1'b1;
                  if (cmd == deq_pkg::CMD_POP_FRONT) begin
                     front_in = front_next;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            deq_pkg::CMD_POP_REAR, deq_pkg::CMD_PEEK_REAR: begin
               if (at_empty) begin
                  meta_in.status = deq_pkg::ST_EMPTY;
               end else begin
                  rd_en            = 1'b1;
                  rd_addr          = rear_prev;
                  meta_in.use_data = 1'b1;
                  if (cmd == deq_pkg::CMD_POP_REAR) begin
                     rear_in  = rear_prev;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
            deq_pkg::CMD_CLEAR: begin
               front_in = '0;
               rear_in  = '0;
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
         meta_ff  <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
         meta_ff  <= meta_in;
      end
   end

   assign meta  = meta_ff;
   assign count = count_ff;

endmodule

// ----- hdl/double_ended_queue.sv -----
// Top level of the bounded double-ended queue held in a ring store.
//
// Command channel: drive req_cmd and req_data with start high; the beat is
// taken at a rising edge where start is high and busy is low. Commands are
// push front, push rear, pop front, pop rear, peek front, peek rear, clear.
// Result channel: every beat gives one result in the cycle after it is
// taken, shown for one cycle with rsp_valid high: rsp_value, rsp_status
// (ok, empty, full), rsp_count after the command and rsp_empty_res.
// The receiver cannot stall; results must be taken when shown.
// Throughput: one command per cycle while busy is low. The result is
// registered, as is the read port of the store RAM; a push writes the
// RAM in the accept cycle, so a read in the next cycle already sees it.
// Reset (synchronous, active high) empties the queue and holds busy high
// until the cycle after reset falls; the store contents are not cleared.
module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_cmd,
   input  logic signed [DATA_WIDTH-1:0]      req_data,
   output logic                              rsp_valid,
   output logic signed [DATA_WIDTH-1:0]      rsp_value,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count,
   output logic                              rsp_empty_res
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                  busy_ff;
   logic                  accept;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic [CW-1:0]         count;
   deq_pkg::rsp_meta_type meta;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff | reset;
   assign accept = start & ~busy;

   deq_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_cmd),
      .data    (req_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .meta    (meta),
      .count   (count)
   );

   deq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid     = meta.valid;
   assign rsp_value     = meta.use_data ? rd_data : '0;
   assign rsp_status    = meta.status;
   assign rsp_count     = count;
   assign rsp_empty_res = (count == '0);

endmodule

// ----- hdl/deq_checker.sv -----
// Port-level assertions for the double-ended queue and their bind.
module deq_checker #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [DATA_WIDTH-1:0]        rsp_value,
   input logic [1:0]                   rsp_status,
   input logic [$clog2(DEPTH+1)-1:0]   rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   a_one_result_per_beat: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (rsp_valid == $past(start && !busy)))
      else $error("result strobe does not follow the accepted beat");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::ST_EMPTY) |-> (rsp_value == '0 && rsp_count == '0))
      else $error("empty status with nonzero value or count");

   a_full_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == deq_pkg::ST_FULL) |-> (rsp_count == CW'(DEPTH)))
      else $error("full status while queue not full");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(rsp_valid) && rsp_status != deq_pkg::ST_OK)
         |-> (rsp_count == $past(rsp_count)))
      else $error("rejected command changed the entry count");

endmodule

bind double_ended_queue deq_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count)
);

// ----- dv/tb_double_ended_queue.sv -----
// Self-checking testbench for the double-ended queue: directed and random commands.
module tb_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = deq_pkg::DEPTH_DEFAULT;
   localparam int DATA_WIDTH     = deq_pkg::DATA_WIDTH_DEFAULT;
   localparam int IDX_W          = $clog2(DEPTH);
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct {
      logic signed [DATA_WIDTH-1:0] value;
      deq_pkg::status_type          status;
      logic [CNT_W-1:0]             count;
      logic                         empty_res;
   } deq_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [2:0]                    req_cmd = deq_pkg::CMD_UNUSED;
   logic signed [DATA_WIDTH-1:0]  req_data = '0;
   logic                          rsp_valid;
   logic signed [DATA_WIDTH-1:0]  rsp_value;
   logic [1:0]                    rsp_status;
   logic [CNT_W-1:0]              rsp_count;
   logic                          rsp_empty_res;

   logic signed [DATA_WIDTH-1:0]  shadow_store [DEPTH];
   logic [IDX_W-1:0]              shadow_front = '0;
   logic [IDX_W-1:0]              shadow_rear = '0;
   logic [CNT_W-1:0]              shadow_count = '0;

   deq_result_type                pending_results [$];
   int                            fail_count = 0;
   int                            idle_cycles = 0;

   double_ended_queue #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_value     (rsp_value),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_empty_res (rsp_empty_res)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic predict_deque_op(input deq_pkg::cmd_type cmd,
                                   input logic signed [DATA_WIDTH-1:0] word);
      deq_result_type r;
      r.value  = '0;
      r.status = deq_pkg::ST_OK;
      case (cmd)
         deq_pkg::CMD_PUSH_FRONT: begin
            if (shadow_count == DEPTH) begin
               r.status = deq_pkg::ST_FULL;
            end else begin
               shadow_front               = shadow_front - 1'b1;
               shadow_store[shadow_front] = word;
               shadow_count               = shadow_count + 1'b1;
            end
         end
         deq_pkg::CMD_PUSH_REAR: begin
            if (shadow_count == DEPTH) begin
               r.status = deq_pkg::ST_FULL;
            end else begin
               shadow_store[shadow_rear] = word;
               shadow_rear               = shadow_rear + 1'b1;
               shadow_count              = shadow_count + 1'b1;
            end
         end
         deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
            if (shadow_count == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else begin
               r.value = shadow_store[shadow_front];
               if (cmd == deq_pkg::CMD_POP_FRONT) begin
                  shadow_front = shadow_front + 1'b1;
                  shadow_count = shadow_count - 1'b1;
               end
            end
         end
         deq_pkg::CMD_POP_REAR, deq_pkg::CMD_PEEK_REAR: begin
            if (shadow_count == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else begin
               r.value = shadow_store[shadow_rear - 1'b1];
               if (cmd == deq_pkg::CMD_POP_REAR) begin
                  shadow_rear  = shadow_rear - 1'b1;
                  shadow_count = shadow_count - 1'b1;
               end
            end
         end
         deq_pkg::CMD_CLEAR: begin
            shadow_front = '0;
            shadow_rear  = '0;
            shadow_count = '0;
         end
         default: begin
         end
      endcase
      r.count     = shadow_count;
      r.empty_res = (shadow_count == 0);
      pending_results.push_back(r);
   endtask

   // hold start high until the beat is taken, then predict it
   task automatic send_beat(input deq_pkg::cmd_type cmd,
                            input logic signed [DATA_WIDTH-1:0] word);
      start    <= 1'b1;
      req_cmd  <= cmd;
      req_data <= word;
      do @(posedge clock); while (busy);
      predict_deque_op(cmd, word);
   endtask

   task automatic idle_sender(input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_empty_queue();
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sd5);
      send_beat(deq_pkg::CMD_PEEK_REAR, -32'sd5);
      send_beat(deq_pkg::CMD_UNUSED, 32'sh7fff_ffff);
   endtask

   task automatic test_fill_to_full();
      send_beat(deq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000);
      send_beat(deq_pkg::CMD_PUSH_REAR, 32'sh7fff_ffff);
      for (int i = 2; i < DEPTH; i++) begin
         send_beat((i % 2) ? deq_pkg::CMD_PUSH_REAR : deq_pkg::CMD_PUSH_FRONT, $urandom);
      end
      send_beat(deq_pkg::CMD_PUSH_FRONT, -32'sd1);
      send_beat(deq_pkg::CMD_PUSH_REAR, 32'sd0);
   endtask

   task automatic test_drain_both_ends();
      send_beat(deq_pkg::CMD_PEEK_FRONT, 32'sd0);
      send_beat(deq_pkg::CMD_PEEK_REAR, 32'sd0);
      send_beat(deq_pkg::CMD_POP_FRONT, 32'sd0);
      send_beat(deq_pkg::CMD_POP_REAR, 32'sd0);
   endtask

   task automatic test_clear();
      send_beat(deq_pkg::CMD_CLEAR, $urandom);
      send_beat(deq_pkg::CMD_POP_REAR, 32'sd0);
      send_beat(deq_pkg::CMD_PEEK_FRONT, 32'sd0);
   endtask

   // steer the fill level toward a moving target so both full and empty are hit
   task automatic test_random_traffic(input int beats, input int idle_pct, input bit pause_midway);
      int                           target;
      int                           roll;
      bit                           want_push;
      deq_pkg::cmd_type             cmd;
      logic signed [DATA_WIDTH-1:0] word;
      target = 0;
      for (int i = 0; i < beats; i++) begin
         if (i % 24 == 0) begin
            case ($urandom_range(0, 3))
               0:       target = 0;
               1:       target = DEPTH;
               default: target = $urandom_range(1, DEPTH);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            cmd = deq_pkg::CMD_CLEAR;
         end else if (roll < 3) begin
            cmd = deq_pkg::CMD_UNUSED;
         end else if (roll < 12) begin
            cmd = $urandom_range(0, 1) ? deq_pkg::CMD_PEEK_FRONT : deq_pkg::CMD_PEEK_REAR;
         end else begin
            want_push = (shadow_count < target) ? (roll < 78) : (roll >= 78);
            if (want_push) begin
               cmd = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_REAR;
            end else begin
               cmd = $urandom_range(0, 1) ? deq_pkg::CMD_POP_FRONT : deq_pkg::CMD_POP_REAR;
            end
         end
         case ($urandom_range(0, 7))
            0:       word = 32'sh8000_0000;
            1:       word = 32'sh7fff_ffff;
            2:       word = '0;
            3:       word = -32'sd1;
            default: word = $urandom;
         endcase
         send_beat(cmd, word);
         if (pause_midway && i == beats / 2) begin
            wait_for_drain();
         end else begin
            idle_sender(idle_pct);
         end
      end
   endtask

   always @(posedge clock) begin
      deq_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: value %0d status %0d count %0d",
                   rsp_value, rsp_status, rsp_count);
            fail_count++;
         end else begin
            exp_r = pending_results[0];
            pending_results.delete(0);
            if (rsp_value !== exp_r.value) begin
               $error("rsp_value expected %0d got %0d", exp_r.value, rsp_value);
               fail_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("rsp_status expected %0d got %0d", exp_r.status, rsp_status);
               fail_count++;
            end
            if (rsp_count !== exp_r.count) begin
               $error("rsp_count expected %0d got %0d", exp_r.count, rsp_count);
               fail_count++;
            end
            if (rsp_empty_res !== exp_r.empty_res) begin
               $error("rsp_empty_res expected %0d got %0d", exp_r.empty_res, rsp_empty_res);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_fill_to_full();
      test_drain_both_ends();
      test_clear();
      wait_for_drain();
      test_random_traffic(130, 32, 1'b1);
      wait_for_drain();
      test_random_traffic(130, 61, 1'b0);
      wait_for_drain();
      test_random_traffic(140, 0, 1'b0);
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue.sv
hdl/deq_checker.sv
dv/tb_double_ended_queue.sv
